/* rtl/core/scaled_moving_average_threshold_top_defines.svh */
// Assertion helpers used by the top-level RTL file of the block.
// Every use expects signals named clock and reset in the enclosing module.
`ifndef SCALED_MOVING_AVERAGE_THRESHOLD_TOP_DEFINES_SVH
`define SCALED_MOVING_AVERAGE_THRESHOLD_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SMAT_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("smat: same-cycle check failed");

// next-cycle implication
`define SMAT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("smat: next-cycle check failed");

`else

`define SMAT_ASSERT_IMPL(label, ante, cons)

`define SMAT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/core/smat_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package smat_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int AVG_W      = 16;
   localparam int GAIN_W     = 17;
   localparam int SHIFT_W    = 6;
   localparam int CSR_DATA_W = 17;
   localparam int CSR_IDX_W  = 3;

   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 17'h10000;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN,
      CSR_GAIN_SHIFT,
      CSR_BIAS,
      CSR_LOW_THRESHOLD,
      CSR_HIGH_THRESHOLD,
      CSR_LOW_ENABLE,
      CSR_HIGH_ENABLE
   } csr_index_type;

endpackage

`default_nettype wire

/* rtl/core/smat_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface smat_req_if;
   logic                          valid;
   logic                          ready;
   logic [smat_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface smat_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [smat_pkg::AVG_W-1:0] average;
   logic                              fell_below;
   logic                              rose_above;

   modport source (output valid, output average, output fell_below, output rose_above,
                   input ready);
   modport sink   (input valid, input average, input fell_below, input rose_above,
                   output ready);
endinterface

`default_nettype wire

/* rtl/core/scaled_moving_average_threshold_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Scaled moving average with threshold crossing flags. Each sample word is
// scaled by gain, shifted right by gain_shift, offset by bias and saturated to
// int16, then written over the oldest entry of a WINDOW-deep ring held in a
// synchronous RAM; the result word carries the ring average (sum / WINDOW,
// truncated toward zero) and the low/high crossing flags. One word is taken
// per clock while no result is stalled; the rate rests on the running-sum
// update and the read-modify-write of the ring RAM, with a bypass when the
// word two places back wrote the entry being read. A stalled result holds
// the whole pipeline. Ring entries read as zero until first written;
// per-entry valid bits clear on reset, so no clearing pass is needed.

`include "scaled_moving_average_threshold_top_defines.svh"

module scaled_moving_average_threshold_top #(
   parameter int WINDOW = 10
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   smat_req_if.sink                               req,
   smat_rsp_if.source                             rsp,
   input  wire logic                              csr_wr_en,
   input  wire logic [smat_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [smat_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W  = 16 + $clog2(WINDOW);
   localparam int PROD_W = smat_pkg::SAMPLE_W + smat_pkg::GAIN_W;
   localparam int BIAS_W = PROD_W + 2;

   localparam logic [SLOT_W-1:0]       SLOT_LAST = SLOT_W'(WINDOW - 1);
   localparam logic [SUM_W-1:0]        WIN_SUM   = SUM_W'(WINDOW);
   localparam logic [SUM_W-1:0]        WIN_TWICE = SUM_W'(2 * WINDOW);
   // floor(2^SUM_W / WINDOW): quotient estimate is low by at most one
   localparam logic [SUM_W-1:0]        RECIP     = SUM_W'((64'd1 << SUM_W) / WINDOW);
   localparam logic signed [SUM_W-1:0] SUM_MAX   = SUM_W'(WINDOW * 32767);
   localparam logic signed [SUM_W-1:0] SUM_MIN   = SUM_W'(-(WINDOW * 32768));

   // configuration registers
   logic [smat_pkg::GAIN_W-1:0]  gain_ff;
   logic [smat_pkg::SHIFT_W-1:0] shift_ff;
   logic signed [15:0]           bias_ff;
   logic signed [15:0]           low_thr_ff;
   logic signed [15:0]           high_thr_ff;
   logic                         low_en_ff;
   logic                         high_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff     <= smat_pkg::GAIN_RESET;
         shift_ff    <= smat_pkg::SHIFT_RESET;
         bias_ff     <= '0;
         low_thr_ff  <= '0;
         high_thr_ff <= '0;
         low_en_ff   <= 1'b0;
         high_en_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            smat_pkg::CSR_GAIN:           gain_ff     <= csr_wdata[smat_pkg::GAIN_W-1:0];
            smat_pkg::CSR_GAIN_SHIFT:     shift_ff    <= csr_wdata[smat_pkg::SHIFT_W-1:0];
            smat_pkg::CSR_BIAS:           bias_ff     <= $signed(csr_wdata[15:0]);
            smat_pkg::CSR_LOW_THRESHOLD:  low_thr_ff  <= $signed(csr_wdata[15:0]);
            smat_pkg::CSR_HIGH_THRESHOLD: high_thr_ff <= $signed(csr_wdata[15:0]);
            smat_pkg::CSR_LOW_ENABLE:     low_en_ff   <= csr_wdata[0];
            smat_pkg::CSR_HIGH_ENABLE:    high_en_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves together; it stops only when a result word is stuck
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || rsp.ready;
   assign req.ready = adv;

   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_in;

   assign slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;

   // ring RAM and its entry-valid bits
   logic signed [15:0] ring_mem [WINDOW];
   logic signed [15:0] rd_data_ff;
   logic [WINDOW-1:0]  valid_ff;

   // stage 1: product registered, ring entry read
   logic                v1_ff;
   logic [PROD_W-1:0]   prod1_ff;
   logic [SLOT_W-1:0]   slot1_ff;
   logic                vbit1_ff;
   logic                byp1_ff;
   logic signed [15:0]  byp_data1_ff;

   // stage 2: conditioned value and evicted entry
   logic                v2_ff;
   logic signed [15:0]  cond2_ff;
   logic signed [15:0]  old2_ff;
   logic [SLOT_W-1:0]   slot2_ff;

   // stage 3: running sum
   logic                    v3_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] sum_in;

   // stage 4: magnitude times reciprocal
   logic                 v4_ff;
   logic                 neg4_ff;
   logic [SUM_W-1:0]     mag4_ff;
   logic [2*SUM_W-1:0]   qp4_ff;

   // stage 5: quotient estimate and its back-product
   logic                 v5_ff;
   logic                 neg5_ff;
   logic [SUM_W-1:0]     mag5_ff;
   logic [15:0]          q0_5_ff;
   logic [SUM_W-1:0]     pw5_ff;

   logic signed [15:0]   rsp_avg_ff;
   logic                 rsp_fell_ff;
   logic                 rsp_rose_ff;
   logic signed [15:0]   last_avg_ff;

   // conditioning: shift, bias, saturate
   logic [PROD_W-1:0]        shifted_w;
   logic signed [BIAS_W-1:0] biased_w;
   logic signed [15:0]       cond_w;

   always_comb begin
      shifted_w = prod1_ff >> shift_ff;
      biased_w  = $signed({2'b00, shifted_w}) +
                  $signed({{(BIAS_W-16){bias_ff[15]}}, bias_ff});
      if (biased_w > $signed(BIAS_W'(32767))) begin
         cond_w = 16'sh7fff;
      end else if (biased_w < $signed(-BIAS_W'(32768))) begin
         cond_w = 16'sh8000;
      end else begin
         cond_w = biased_w[15:0];
      end
   end

   assign sum_in = sum_ff + {{(SUM_W-16){cond2_ff[15]}}, cond2_ff}
                          - {{(SUM_W-16){old2_ff[15]}}, old2_ff};

   logic [SUM_W-1:0] mag_w;
   logic [15:0]      q0_w;
   logic [SUM_W-1:0] rem_w;
   logic [15:0]      q_w;
   logic signed [15:0] avg_w;

   always_comb begin
      mag_w = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      q0_w  = qp4_ff[SUM_W +: 16];
      rem_w = mag5_ff - pw5_ff;
      q_w   = q0_5_ff + 16'((rem_w >= WIN_SUM) ? 1 : 0);
      avg_w = neg5_ff ? -$signed(q_w) : $signed(q_w);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_data_ff <= ring_mem[slot_ff];
         if (v2_ff) begin
            ring_mem[slot2_ff] <= cond2_ff;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         valid_ff     <= '0;
         sum_ff       <= '0;
         last_avg_ff  <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req.valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         rsp_valid_ff <= v5_ff;
         if (req.valid) begin
            slot_ff <= slot_in;
         end
         if (v2_ff) begin
            sum_ff             <= sum_in;
            valid_ff[slot2_ff] <= 1'b1;
         end
         if (v5_ff) begin
            last_avg_ff <= avg_w;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (adv) begin
         prod1_ff     <= PROD_W'(req.sample) * PROD_W'(gain_ff);
         slot1_ff     <= slot_ff;
         vbit1_ff     <= valid_ff[slot_ff];
         // entry being written this edge is read stale from the RAM
         byp1_ff      <= v2_ff && (slot2_ff == slot_ff);
         byp_data1_ff <= cond2_ff;

         cond2_ff <= cond_w;
         slot2_ff <= slot1_ff;
         if (byp1_ff) begin
            old2_ff <= byp_data1_ff;
         end else if (vbit1_ff) begin
            old2_ff <= rd_data_ff;
         end else begin
            old2_ff <= '0;
         end

         neg4_ff <= sum_ff[SUM_W-1];
         mag4_ff <= mag_w;
         qp4_ff  <= (2*SUM_W)'(mag_w) * (2*SUM_W)'(RECIP);

         neg5_ff <= neg4_ff;
         mag5_ff <= mag4_ff;
         q0_5_ff <= q0_w;
         pw5_ff  <= SUM_W'(q0_w) * WIN_SUM;

         rsp_avg_ff  <= avg_w;
         rsp_fell_ff <= low_en_ff && (avg_w < low_thr_ff) && (last_avg_ff >= low_thr_ff);
         rsp_rose_ff <= high_en_ff && (avg_w > high_thr_ff) && (last_avg_ff <= high_thr_ff);
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.average    = rsp_avg_ff;
   assign rsp.fell_below = rsp_fell_ff;
   assign rsp.rose_above = rsp_rose_ff;

   `SMAT_ASSERT_IMPL(sum_in_range_a, 1'b1, (sum_ff <= SUM_MAX) && (sum_ff >= SUM_MIN))
   `SMAT_ASSERT_IMPL(slot_in_range_a, 1'b1, slot_ff <= SLOT_LAST)
   `SMAT_ASSERT_IMPL(stall_blocks_input_a, rsp.valid && !rsp.ready, !req.ready)
   `SMAT_ASSERT_IMPL(recip_error_a, v5_ff, (mag5_ff >= pw5_ff) && (rem_w < WIN_TWICE))
   `SMAT_ASSERT_NEXT(ring_entry_valid_a, adv && v2_ff, valid_ff[$past(slot2_ff)])

endmodule

`default_nettype wire
